// ----- rtl/urtb_pkg.sv -----
// shared types and constants for the receive ring and transmit buffer unit
package urtb_pkg;

    localparam int DATA_W       = 8;
    localparam int RX_COUNT_W   = 7;
    localparam int RX_COUNT_MAX = 127;

    typedef enum logic [1:0] {
        MODE_RX_BYTE = 2'd0,
        MODE_READ    = 2'd1,
        MODE_APPEND  = 2'd2,
        MODE_TICK    = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_BUSY  = 2'd1,
        ST_TRUNC = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        OP_NONE  = 3'd0,
        OP_RX_WR = 3'd1,
        OP_RX_RD = 3'd2,
        OP_TX_WR = 3'd3,
        OP_TX_RD = 3'd4
    } t_mem_op;

    typedef struct packed {
        t_mem_op                op;
        t_status                status;
        logic                   dropped;
        logic [RX_COUNT_W-1:0]  rx_count;
        logic                   tx_sending;
        logic                   tx_armed;
    } t_cmd;

endpackage

// ----- rtl/urtb_front.sv -----
// front end: accepts items, updates pointers and counts, issues store commands
module urtb_front
    import urtb_pkg::*;
#(
    parameter int RX_DEPTH = 128,
    parameter int TX_DEPTH = 128,
    parameter int RX_AW    = 7,
    parameter int TX_AW    = 7,
    parameter int TX_CW    = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  t_mode             i_mode,
    input  logic [DATA_W-1:0] i_data_in,
    input  logic              i_last_byte,
    output t_cmd              o_cmd,
    output logic [RX_AW-1:0]  o_rx_addr,
    output logic [TX_AW-1:0]  o_tx_addr,
    output logic [DATA_W-1:0] o_wdata
);

    localparam int RX_CW = RX_AW + 1;
    localparam int EXT_W = RX_CW + RX_COUNT_W;

    logic [RX_AW-1:0] r_rx_head, n_rx_head;
    logic [RX_AW-1:0] r_rx_tail, n_rx_tail;
    logic [TX_CW-1:0] r_tx_next, n_tx_next;
    logic [TX_CW-1:0] r_tx_remaining, n_tx_remaining;
    logic [TX_CW-1:0] r_load_count, n_load_count;
    logic             r_ready_enable, n_ready_enable;

    logic [RX_AW-1:0] head_adv;
    logic [RX_AW-1:0] tail_adv;
    logic [RX_CW-1:0] diff;
    logic [EXT_W-1:0] diff_ext;

    assign head_adv = (r_rx_head == RX_AW'(RX_DEPTH - 1)) ? '0 : r_rx_head + 1'b1;
    assign tail_adv = (r_rx_tail == RX_AW'(RX_DEPTH - 1)) ? '0 : r_rx_tail + 1'b1;

    always_comb begin
        n_rx_head      = r_rx_head;
        n_rx_tail      = r_rx_tail;
        n_tx_next      = r_tx_next;
        n_tx_remaining = r_tx_remaining;
        n_load_count   = r_load_count;
        n_ready_enable = r_ready_enable;
        o_cmd.op       = OP_NONE;
        o_cmd.status   = ST_OK;
        o_cmd.dropped  = 1'b0;
        o_rx_addr      = r_rx_head;
        o_tx_addr      = r_load_count[TX_AW-1:0];
        o_wdata        = i_data_in;
        case (i_mode)
            MODE_RX_BYTE: begin
                o_cmd.op  = OP_RX_WR;
                o_rx_addr = r_rx_head;
                n_rx_head = head_adv;
                if (head_adv == r_rx_tail) begin
                    n_rx_tail     = tail_adv;
                    o_cmd.dropped = 1'b1;
                end
            end
            MODE_READ: begin
                if (r_rx_head != r_rx_tail) begin
                    o_cmd.op  = OP_RX_RD;
                    o_rx_addr = r_rx_tail;
                    n_rx_tail = tail_adv;
                end
            end
            MODE_APPEND: begin
                if (r_tx_remaining != '0) begin
                    o_cmd.status = ST_BUSY;
                end else begin
                    if (r_load_count < TX_CW'(TX_DEPTH)) begin
                        o_cmd.op     = OP_TX_WR;
                        o_tx_addr    = r_load_count[TX_AW-1:0];
                        n_load_count = r_load_count + 1'b1;
                    end else begin
                        o_cmd.status = ST_TRUNC;
                    end
                    if (i_last_byte) begin
                        n_tx_remaining = n_load_count;
                        n_tx_next      = '0;
                        n_load_count   = '0;
                        n_ready_enable = 1'b1;
                    end
                end
            end
            MODE_TICK: begin
                if (r_tx_remaining != '0) begin
                    o_cmd.op       = OP_TX_RD;
                    o_tx_addr      = r_tx_next[TX_AW-1:0];
                    n_tx_next      = r_tx_next + 1'b1;
                    n_tx_remaining = r_tx_remaining - 1'b1;
                end else begin
                    n_ready_enable = 1'b0;
                end
            end
            default: begin
                o_cmd.op = OP_NONE;
            end
        endcase

        if (n_rx_head >= n_rx_tail) begin
            diff = RX_CW'(n_rx_head) - RX_CW'(n_rx_tail);
        end else begin
            diff = RX_CW'(n_rx_head) + RX_CW'(RX_DEPTH) - RX_CW'(n_rx_tail);
        end
        diff_ext = EXT_W'(diff);
        o_cmd.rx_count = (diff_ext > EXT_W'(RX_COUNT_MAX)) ?
                         RX_COUNT_W'(RX_COUNT_MAX) : diff_ext[RX_COUNT_W-1:0];
        o_cmd.tx_sending = (n_tx_remaining != '0);
        o_cmd.tx_armed   = n_ready_enable;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rx_head      <= '0;
            r_rx_tail      <= '0;
            r_tx_next      <= '0;
            r_tx_remaining <= '0;
            r_load_count   <= '0;
            r_ready_enable <= 1'b0;
        end else if (i_push) begin
            r_rx_head      <= n_rx_head;
            r_rx_tail      <= n_rx_tail;
            r_tx_next      <= n_tx_next;
            r_tx_remaining <= n_tx_remaining;
            r_load_count   <= n_load_count;
            r_ready_enable <= n_ready_enable;
        end
    end

endmodule

// ----- rtl/urtb_fifo.sv -----
// two-entry command queue between front end and back end
module urtb_fifo #(
    parameter int WIDTH = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);

    logic [WIDTH-1:0] r_entry [2];
    logic             r_wr_ptr;
    logic             r_rd_ptr;
    logic [1:0]       r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_entry[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ----- rtl/urtb_back.sv -----
// back end: receive and transmit stores plus the result register
module urtb_back
    import urtb_pkg::*;
#(
    parameter int RX_DEPTH = 128,
    parameter int TX_DEPTH = 128,
    parameter int RX_AW    = 7,
    parameter int TX_AW    = 7
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cmd_valid,
    output logic                  o_cmd_pop,
    input  t_cmd                  i_cmd,
    input  logic [RX_AW-1:0]      i_rx_addr,
    input  logic [TX_AW-1:0]      i_tx_addr,
    input  logic [DATA_W-1:0]     i_wdata,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [DATA_W-1:0]     o_data_out,
    output logic                  o_data_valid,
    output logic [1:0]            o_status,
    output logic                  o_dropped_oldest,
    output logic [RX_COUNT_W-1:0] o_rx_count,
    output logic                  o_tx_sending,
    output logic                  o_tx_armed
);

    logic [DATA_W-1:0] rx_mem [RX_DEPTH];
    logic [DATA_W-1:0] tx_mem [TX_DEPTH];
    logic [DATA_W-1:0] r_rx_rd;
    logic [DATA_W-1:0] r_tx_rd;
    t_cmd              r_cmd;
    logic              r_out_valid;

    assign o_cmd_pop = i_cmd_valid && (!r_out_valid || i_out_ready);

    always_ff @(posedge i_clk) begin
        if (o_cmd_pop && (i_cmd.op == OP_RX_WR)) begin
            rx_mem[i_rx_addr] <= i_wdata;
        end
        if (o_cmd_pop && (i_cmd.op == OP_RX_RD)) begin
            r_rx_rd <= rx_mem[i_rx_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_pop && (i_cmd.op == OP_TX_WR)) begin
            tx_mem[i_tx_addr] <= i_wdata;
        end
        if (o_cmd_pop && (i_cmd.op == OP_TX_RD)) begin
            r_tx_rd <= tx_mem[i_tx_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) begin
            r_cmd <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_cmd_pop) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_comb begin
        case (r_cmd.op)
            OP_RX_RD: o_data_out = r_rx_rd;
            OP_TX_RD: o_data_out = r_tx_rd;
            default:  o_data_out = '0;
        endcase
    end

    assign o_out_valid      = r_out_valid;
    assign o_data_valid     = (r_cmd.op == OP_RX_RD) || (r_cmd.op == OP_TX_RD);
    assign o_status         = r_cmd.status;
    assign o_dropped_oldest = r_cmd.dropped;
    assign o_rx_count       = r_cmd.rx_count;
    assign o_tx_sending     = r_cmd.tx_sending;
    assign o_tx_armed       = r_cmd.tx_armed;

endmodule

// ----- rtl/uart_rx_ring_tx_buffer_unit.sv -----
// top level of the receive ring and transmit buffer unit
// Takes one item per cycle unless stalled and returns one result per item in
// order. The front end updates ring pointers and transmit counts in the cycle
// an item is transferred and queues one store command; the back end performs
// that single store access and registers the result, so items pass through the
// two-entry command queue and the result register. The rate is one item per
// cycle while the output is not stalled, bounded by the one store access per
// item in the back end. The receive ring holds RX_DEPTH-1 bytes and overwrites
// the oldest when full; the transmit buffer holds TX_DEPTH bytes. The stores
// need no clearing after reset, so items are taken as soon as reset is released.
module uart_rx_ring_tx_buffer_unit
    import urtb_pkg::*;
#(
    parameter int RX_DEPTH = 128,
    parameter int TX_DEPTH = 128
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [1:0]            i_mode,
    input  logic [DATA_W-1:0]     i_data_in,
    input  logic                  i_last_byte,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [DATA_W-1:0]     o_data_out,
    output logic                  o_data_valid,
    output logic [1:0]            o_status,
    output logic                  o_dropped_oldest,
    output logic [RX_COUNT_W-1:0] o_rx_count,
    output logic                  o_tx_sending,
    output logic                  o_tx_armed
);

    localparam int RX_AW  = $clog2(RX_DEPTH);
    localparam int TX_AW  = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;
    localparam int TX_CW  = $clog2(TX_DEPTH + 1);
    localparam int CMD_W  = $bits(t_cmd);
    localparam int FIFO_W = CMD_W + RX_AW + TX_AW + DATA_W;

    logic              push;
    logic              fifo_full;
    logic              fifo_valid;
    logic              fifo_pop;
    t_cmd              f_cmd;
    logic [RX_AW-1:0]  f_rx_addr;
    logic [TX_AW-1:0]  f_tx_addr;
    logic [DATA_W-1:0] f_wdata;
    logic [FIFO_W-1:0] q_out;
    t_cmd              b_cmd;

    assign o_in_ready = !fifo_full;
    assign push       = i_in_valid && o_in_ready;

    urtb_front #(
        .RX_DEPTH (RX_DEPTH),
        .TX_DEPTH (TX_DEPTH),
        .RX_AW    (RX_AW),
        .TX_AW    (TX_AW),
        .TX_CW    (TX_CW)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_mode      (t_mode'(i_mode)),
        .i_data_in   (i_data_in),
        .i_last_byte (i_last_byte),
        .o_cmd       (f_cmd),
        .o_rx_addr   (f_rx_addr),
        .o_tx_addr   (f_tx_addr),
        .o_wdata     (f_wdata)
    );

    urtb_fifo #(
        .WIDTH (FIFO_W)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({f_cmd, f_rx_addr, f_tx_addr, f_wdata}),
        .o_full  (fifo_full),
        .i_pop   (fifo_pop),
        .o_valid (fifo_valid),
        .o_data  (q_out)
    );

    assign b_cmd = t_cmd'(q_out[FIFO_W-1 -: CMD_W]);

    urtb_back #(
        .RX_DEPTH (RX_DEPTH),
        .TX_DEPTH (TX_DEPTH),
        .RX_AW    (RX_AW),
        .TX_AW    (TX_AW)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd_valid      (fifo_valid),
        .o_cmd_pop        (fifo_pop),
        .i_cmd            (b_cmd),
        .i_rx_addr        (q_out[DATA_W+TX_AW +: RX_AW]),
        .i_tx_addr        (q_out[DATA_W +: TX_AW]),
        .i_wdata          (q_out[DATA_W-1:0]),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_data_out       (o_data_out),
        .o_data_valid     (o_data_valid),
        .o_status         (o_status),
        .o_dropped_oldest (o_dropped_oldest),
        .o_rx_count       (o_rx_count),
        .o_tx_sending     (o_tx_sending),
        .o_tx_armed       (o_tx_armed)
    );

endmodule
